// ===== design/dfr_pkg.sv =====
// Shared types, codes and helpers for the WebSocket frame deframer.
package dfr_pkg;

  // Default width of the payload length counter
  localparam int LENGTH_BITS_DEF = 32;

  // Opcodes that the action decode cares about
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CTRL  = 4'h8;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  // 7-bit length codes that select an extended length field
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Header field sizes in bytes
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] MASK_BYTES  = 4'd4;

  typedef enum logic [1:0] {
    ACT_TEXT    = 2'd0,
    ACT_CLOSE   = 2'd1,
    ACT_PONG    = 2'd2,
    ACT_DISCARD = 2'd3
  } action_t;

  // One result item plus its strobe
  typedef struct packed {
    logic       emit;
    logic [7:0] data;
    logic       has;
    action_t    act;
    logic       fin;
    logic       last;
  } result_t;

  // Control frames use their own opcode; data frames use the message opcode
  function automatic action_t action_of(input logic [3:0] frame_op,
                                        input logic [3:0] msg_op);
    logic [3:0] eff;
    eff = (frame_op >= OP_CTRL) ? frame_op : msg_op;
    if (eff == OP_TEXT) begin
      return ACT_TEXT;
    end else if (eff == OP_CLOSE) begin
      return ACT_CLOSE;
    end else if (eff == OP_PING) begin
      return ACT_PONG;
    end
    return ACT_DISCARD;
  endfunction

endpackage

// ===== design/websocket_frame_deframer.sv =====
// WebSocket client-to-server frame deframer, top level.
//
// Input channel: in_valid/in_ready carry one raw stream byte (in_byte) per item.
// Output channel: out_valid/out_ready carry zero or one result per input byte:
// payload_byte (unmasked), has_byte (0 on the end marker of an empty frame),
// action (text, close, pong echo, discard), frame_fin and frame_end.
// Header bytes (first byte, length, extended length, mask key) give no result,
// except the last mask key byte of an empty frame, which gives its end marker.
// Throughput: one byte per cycle while the receiver keeps out_ready high.
// An accepted byte is held in the input register, which feeds a single pass of
// parse and unmask logic into the result register.
// If the receiver stalls, the result register holds and one more byte waits
// in the input register; in_ready then drops until the result is taken.
// After the last item of a close frame, all further bytes are accepted and
// dropped. Reset (rst, synchronous) returns to waiting for a frame header,
// clears the stored opcodes and reopens the block.
module websocket_frame_deframer
  import dfr_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic [1:0] action,
  output logic       frame_fin,
  output logic       frame_end
);

  logic       held;
  logic [7:0] held_byte;
  logic       advance;
  result_t    res;

  // Parse the held byte when the result slot can take a result
  assign advance = held && (!out_valid || out_ready);

  dfr_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .take      (advance),
    .held      (held),
    .held_byte (held_byte)
  );

  dfr_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_data (held_byte),
    .res     (res)
  );

  dfr_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && res.emit),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .has_byte     (has_byte),
    .action       (action),
    .frame_fin    (frame_fin),
    .frame_end    (frame_end)
  );

endmodule

// ===== design/dfr_in_reg.sv =====
// Input register stage of the deframer: holds one received byte.
module dfr_in_reg
  import dfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       held,
  output logic [7:0] held_byte
);

  // Free slot, or the held item leaves this cycle
  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ===== design/dfr_parser.sv =====
// Frame header parser and payload unmasker: one byte per step.
module dfr_parser
  import dfr_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_data,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_B0      = 3'd0,
    PH_B1      = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_MASK    = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             hdr_count, hdr_count_next;
  logic                   fin_flag, fin_flag_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic [3:0]             message_opcode, message_opcode_next;
  logic [LENGTH_BITS-1:0] remaining_length, remaining_length_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_index, mask_index_next;
  logic                   closed_flag, closed_flag_next;

  logic [6:0]             len7;
  logic [3:0]             count_inc;
  logic [3:0]             ext_bytes;
  logic [7:0]             mask_byte;
  logic [LENGTH_BITS-1:0] length_dec;
  action_t                act_cur;

  assign len7       = in_data[6:0];
  assign count_inc  = hdr_count + 4'd1;
  assign ext_bytes  = (phase == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
  assign length_dec = remaining_length - LENGTH_BITS'(1);
  assign act_cur    = action_of(frame_opcode, message_opcode);

  // Mask byte for the current payload position, first key byte first
  always_comb begin
    unique case (mask_index)
      2'd0:    mask_byte = mask_key[31:24];
      2'd1:    mask_byte = mask_key[23:16];
      2'd2:    mask_byte = mask_key[15:8];
      default: mask_byte = mask_key[7:0];
    endcase
  end

  // Next state and result for the byte in the input register
  always_comb begin
    phase_next            = phase;
    hdr_count_next        = hdr_count;
    fin_flag_next         = fin_flag;
    frame_opcode_next     = frame_opcode;
    message_opcode_next   = message_opcode;
    remaining_length_next = remaining_length;
    mask_key_next         = mask_key;
    mask_index_next       = mask_index;
    closed_flag_next      = closed_flag;

    res      = '0;
    res.act  = act_cur;
    res.fin  = fin_flag;

    if (step && !closed_flag) begin
      unique case (phase)
        PH_B1: begin
          if (frame_opcode != OP_CONT && frame_opcode < OP_CTRL) begin
            message_opcode_next = frame_opcode;
          end
          hdr_count_next = 4'd0;
          if (len7 == LEN_EXT16) begin
            remaining_length_next = '0;
            phase_next            = PH_EXT16;
          end else if (len7 == LEN_EXT64) begin
            remaining_length_next = '0;
            phase_next            = PH_EXT64;
          end else begin
            remaining_length_next = LENGTH_BITS'(len7);
            phase_next            = PH_MASK;
          end
        end
        PH_EXT16, PH_EXT64: begin
          // big-endian shift in, upper bytes fall off
          remaining_length_next = {remaining_length[LENGTH_BITS-9:0], in_data};
          if (count_inc == ext_bytes) begin
            hdr_count_next = 4'd0;
            phase_next     = PH_MASK;
          end else begin
            hdr_count_next = count_inc;
          end
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], in_data};
          if (count_inc < MASK_BYTES) begin
            hdr_count_next = count_inc;
          end else begin
            hdr_count_next  = 4'd0;
            mask_index_next = 2'd0;
            if (remaining_length == '0) begin
              // empty frame: one end marker
              res.emit   = 1'b1;
              res.last   = 1'b1;
              phase_next = PH_B0;
              if (act_cur == ACT_CLOSE) begin
                closed_flag_next = 1'b1;
              end
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          mask_index_next       = mask_index + 2'd1;
          remaining_length_next = length_dec;
          res.emit              = 1'b1;
          res.data              = in_data ^ mask_byte;
          res.has               = 1'b1;
          if (length_dec == '0) begin
            res.last        = 1'b1;
            phase_next      = PH_B0;
            hdr_count_next  = 4'd0;
            mask_index_next = 2'd0;
            if (act_cur == ACT_CLOSE) begin
              closed_flag_next = 1'b1;
            end
          end
        end
        default: begin
          // first header byte: FIN and opcode
          fin_flag_next     = in_data[7];
          frame_opcode_next = in_data[3:0];
          phase_next        = PH_B1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_B0;
      hdr_count        <= 4'd0;
      fin_flag         <= 1'b0;
      frame_opcode     <= 4'd0;
      message_opcode   <= 4'd0;
      remaining_length <= '0;
      mask_key         <= '0;
      mask_index       <= 2'd0;
      closed_flag      <= 1'b0;
    end else begin
      phase            <= phase_next;
      hdr_count        <= hdr_count_next;
      fin_flag         <= fin_flag_next;
      frame_opcode     <= frame_opcode_next;
      message_opcode   <= message_opcode_next;
      remaining_length <= remaining_length_next;
      mask_key         <= mask_key_next;
      mask_index       <= mask_index_next;
      closed_flag      <= closed_flag_next;
    end
  end

endmodule

// ===== design/dfr_out_reg.sv =====
// Result register of the deframer: holds one result item for the receiver.
module dfr_out_reg
  import dfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic [1:0] action,
  output logic       frame_fin,
  output logic       frame_end
);

  result_t held;

  // Load only happens when the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      held <= res;
    end
  end

  assign payload_byte = held.data;
  assign has_byte     = held.has;
  assign action       = held.act;
  assign frame_fin    = held.fin;
  assign frame_end    = held.last;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the WebSocket frame deframer: random framed streams, own predictor.
module testbench;
  import dfr_pkg::*;

  localparam int LEN_W          = LENGTH_BITS_DEF;
  localparam int TAIL_ITEMS     = 150;
  localparam int STREAM_ITEMS   = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // Opcodes used only by the stimulus
  localparam logic [3:0] OP_BINARY   = 4'h2;
  localparam logic [3:0] OP_RSV_D_LO = 4'h3;
  localparam logic [3:0] OP_RSV_D_HI = 4'h7;
  localparam logic [3:0] OP_PONG     = 4'hA;
  localparam logic [3:0] OP_RSV_C_LO = 4'hB;
  localparam logic [3:0] OP_RSV_C_HI = 4'hF;

  // Length encodings of the second header byte
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_LEN16, PH_LEN64, PH_KEY, PH_DATA
  } rx_phase_t;

  typedef struct {
    logic [7:0] data;
    bit         drain;  // hold this item until all results are in
  } stream_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic [1:0] action;
  logic       frame_fin;
  logic       frame_end;

  stream_item_t stream_q[$];
  result_t      deframed_q[$];
  int           err_count = 0;
  logic         tail_phase = 1'b0;
  int           idle_cycles = 0;

  // Predictor state
  rx_phase_t        rx_phase = PH_HDR0;
  logic [3:0]       rx_hdr_cnt = '0;
  logic             rx_fin = 1'b0;
  logic [3:0]       rx_frame_op = OP_CONT;
  logic [3:0]       rx_msg_op = OP_CONT;
  logic [LEN_W-1:0] rx_remaining = '0;
  logic [31:0]      rx_key = '0;
  logic [1:0]       rx_key_idx = '0;
  logic             rx_closed = 1'b0;

  always #1 clk = ~clk;

  websocket_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .has_byte     (has_byte),
    .action       (action),
    .frame_fin    (frame_fin),
    .frame_end    (frame_end)
  );

  // Advance the deframer state by one stream byte; emit is set when a result follows
  function automatic result_t deframe_step(input logic [7:0] b);
    result_t    r;
    logic       fire;
    logic [7:0] val;
    logic       has;
    logic       last;
    logic [3:0] eff_op;
    r = '0;
    fire = 1'b0;
    val = 8'h00;
    has = 1'b0;
    last = 1'b0;
    if (rx_closed) return r;
    case (rx_phase)
      PH_HDR1: begin
        if (rx_frame_op != OP_CONT && rx_frame_op < OP_CTRL) rx_msg_op = rx_frame_op;
        rx_hdr_cnt = '0;
        if (b[6:0] == LEN_EXT16) begin
          rx_remaining = '0;
          rx_phase = PH_LEN16;
        end else if (b[6:0] == LEN_EXT64) begin
          rx_remaining = '0;
          rx_phase = PH_LEN64;
        end else begin
          rx_remaining = LEN_W'(b[6:0]);
          rx_phase = PH_KEY;
        end
      end
      PH_LEN16, PH_LEN64: begin
        rx_remaining = {rx_remaining[LEN_W-9:0], b};
        rx_hdr_cnt = rx_hdr_cnt + 1'b1;
        if (rx_hdr_cnt == ((rx_phase == PH_LEN16) ? EXT16_BYTES : EXT64_BYTES)) begin
          rx_hdr_cnt = '0;
          rx_phase = PH_KEY;
        end
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], b};
        rx_hdr_cnt = rx_hdr_cnt + 1'b1;
        if (rx_hdr_cnt == MASK_BYTES) begin
          rx_hdr_cnt = '0;
          rx_key_idx = '0;
          if (rx_remaining == '0) begin
            // empty frame: one end marker
            fire = 1'b1;
            last = 1'b1;
          end else begin
            rx_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        val = b ^ rx_key[8*(3-rx_key_idx) +: 8];
        rx_key_idx = rx_key_idx + 1'b1;
        rx_remaining = rx_remaining - 1'b1;
        fire = 1'b1;
        has = 1'b1;
        last = (rx_remaining == '0);
      end
      default: begin
        rx_fin = b[7];
        rx_frame_op = b[3:0];
        rx_phase = PH_HDR1;
      end
    endcase
    if (fire) begin
      eff_op = (rx_frame_op >= OP_CTRL) ? rx_frame_op : rx_msg_op;
      r.emit = 1'b1;
      r.data = val;
      r.has = has;
      case (eff_op)
        OP_TEXT:  r.act = ACT_TEXT;
        OP_CLOSE: r.act = ACT_CLOSE;
        OP_PING:  r.act = ACT_PONG;
        default:  r.act = ACT_DISCARD;
      endcase
      r.fin = rx_fin;
      r.last = last;
      if (last) begin
        if (r.act == ACT_CLOSE) rx_closed = 1'b1;
        rx_phase = PH_HDR0;
        rx_hdr_cnt = '0;
        rx_key_idx = '0;
      end
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Append one masked frame with random key, payload and ignored header bits
  task automatic queue_frame(input bit drain, input logic fin, input logic [3:0] opcode,
                             input int len, input int form);
    logic [7:0] hdr[$];
    hdr.push_back({fin, 3'($urandom_range(0, 7)), opcode});
    case (form)
      FORM_EXT16: begin
        hdr.push_back({1'($urandom_range(0, 1)), LEN_EXT16});
        hdr.push_back(len[15:8]);
        hdr.push_back(len[7:0]);
      end
      FORM_EXT64: begin
        hdr.push_back({1'($urandom_range(0, 1)), LEN_EXT64});
        // upper half of the extension is dropped by the block
        repeat (4) hdr.push_back(8'($urandom_range(0, 255)));
        hdr.push_back(len[31:24]);
        hdr.push_back(len[23:16]);
        hdr.push_back(len[15:8]);
        hdr.push_back(len[7:0]);
      end
      default: hdr.push_back({1'($urandom_range(0, 1)), len[6:0]});
    endcase
    repeat (4) hdr.push_back(8'($urandom_range(0, 255)));
    repeat (len) hdr.push_back(8'($urandom_range(0, 255)));
    foreach (hdr[i]) stream_q.push_back('{data: hdr[i], drain: drain && i == 0});
  endtask

  // Sender: keeps valid and payload stable until taken, idles in random bursts
  always @(posedge clk) begin : drive_proc
    result_t      exp;
    stream_item_t head;
    logic         nxt_valid;
    logic [7:0]   nxt_byte;
    int           send_gap;
    if (rst) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        exp = deframe_step(in_byte);
        if (exp.emit) deframed_q.push_back(exp);
      end
      nxt_valid = in_valid && !in_ready;
      nxt_byte = in_byte;
      if (!nxt_valid && stream_q.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stream_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 7);
        end else if (!(stream_q[0].drain && deframed_q.size() != 0)) begin
          head = stream_q.pop_front();
          nxt_valid = 1'b1;
          nxt_byte = head.data;
        end
      end
      in_valid <= nxt_valid;
      in_byte <= nxt_byte;
      tail_phase <= (stream_q.size() <= TAIL_ITEMS);
    end
  end

  // Receiver: checks each taken result against the oldest expectation
  always @(posedge clk) begin : monitor_proc
    result_t exp;
    int      stall_left;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          report_error($sformatf("unexpected result byte=%02h has=%0b act=%0d",
                                 payload_byte, has_byte, action));
        end else begin
          exp = deframed_q.pop_front();
          if (payload_byte !== exp.data)
            report_error($sformatf("payload_byte got %02h exp %02h", payload_byte, exp.data));
          if (has_byte !== exp.has)
            report_error($sformatf("has_byte got %0b exp %0b", has_byte, exp.has));
          if (action !== exp.act)
            report_error($sformatf("action got %0d exp %0d", action, exp.act));
          if (frame_fin !== exp.fin)
            report_error($sformatf("frame_fin got %0b exp %0b", frame_fin, exp.fin));
          if (frame_end !== exp.last)
            report_error($sformatf("frame_end got %0b exp %0b", frame_end, exp.last));
        end
      end
      if (tail_phase) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item taken on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_proc
    int frame_no;
    int pick;
    logic [3:0] op;
    int len;
    int form;

    // Directed: continuation before any data, text fragment via 16-bit length,
    // ping inside the message, then a continuation that inherits text
    queue_frame(1'b0, 1'b1, OP_CONT, 0, FORM_SHORT);
    queue_frame(1'b0, 1'b0, OP_TEXT, 2, FORM_EXT16);
    queue_frame(1'b0, 1'b1, OP_PING, 1, FORM_SHORT);
    queue_frame(1'b0, 1'b1, OP_CONT, 1, FORM_SHORT);

    // Random frames, mostly short, a few long ones
    frame_no = 0;
    while (stream_q.size() < STREAM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 6) op = OP_CONT;
      else if (pick < 11) op = OP_TEXT;
      else if (pick < 13) op = OP_BINARY;
      else if (pick < 14) op = 4'($urandom_range(OP_RSV_D_LO, OP_RSV_D_HI));
      else if (pick < 16) op = OP_PING;
      else if (pick < 18) op = OP_PONG;
      else if (pick < 19) op = 4'($urandom_range(OP_RSV_C_LO, OP_RSV_C_HI));
      else op = OP_TEXT;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        form = FORM_SHORT;
        len = $urandom_range(0, 12);
      end else if (pick < 75) begin
        form = FORM_SHORT;
        len = $urandom_range(0, 125);
      end else if (pick < 88) begin
        form = FORM_EXT16;
        len = $urandom_range(0, 200);
      end else if (pick < 98) begin
        form = FORM_EXT64;
        len = $urandom_range(0, 40);
      end else begin
        form = FORM_EXT16;
        len = $urandom_range(300, 600);
      end
      queue_frame(frame_no % 25 == 0, 1'($urandom_range(0, 1)), op, len, form);
      frame_no++;
    end

    // Close frame last; everything after it must be dropped
    queue_frame(1'b0, 1'($urandom_range(0, 1)), OP_CLOSE, $urandom_range(0, 5), FORM_SHORT);
    repeat (20) stream_q.push_back('{data: 8'($urandom_range(0, 255)), drain: 1'b0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (stream_q.size() != 0 || in_valid || deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
